// ----- hw/rtl/tld_pkg.sv -----
package tld_pkg;

	localparam int BUFFER_DEPTH = 64;
	localparam int MAX_READ     = 64;
	localparam int LEN_W        = 7;
	localparam int CMDQ_DEPTH   = 2;
	localparam int RESQ_DEPTH   = 4;

	localparam logic [7:0] KEY_INTR = 8'd3;
	localparam logic [7:0] KEY_STOP = 8'd26;
	localparam logic [7:0] KEY_BS   = 8'd8;
	localparam logic [7:0] KEY_DEL  = 8'd127;
	localparam logic [7:0] KEY_LF   = 8'd10;
	localparam logic [7:0] KEY_CR   = 8'd13;

	typedef enum logic [1:0] {
		CFG_CANON   = 2'd0,
		CFG_SIGKEYS = 2'd1,
		CFG_FGROUP  = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_INTR  = 2'd2
	} res_kind_t;

	typedef enum logic [2:0] {
		OP_INTR      = 3'd0,
		OP_ERASE     = 3'd1,
		OP_NEWLINE   = 3'd2,
		OP_APPEND    = 3'd3,
		OP_RAW       = 3'd4,
		OP_READ_LINE = 3'd5,
		OP_READ_RAW  = 3'd6
	} cmd_op_t;

	typedef enum logic [1:0] {
		ST_IDLE      = 2'd0,
		ST_READ_LINE = 2'd1,
		ST_READ_RAW  = 2'd2
	} back_state_t;

	typedef struct packed {
		cmd_op_t           op;
		logic [7:0]        chr;
		logic [LEN_W-1:0]  len;
		logic [15:0]       group;
	} cmd_t;

	typedef struct packed {
		res_kind_t   kind;
		logic [7:0]  data;
		logic        last;
		logic [15:0] group;
	} res_t;

endpackage

// ----- hw/rtl/tld_fifo.sv -----
module tld_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [W-1:0]               wdata,
	input  logic                       pop,
	output logic [W-1:0]               rdata,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign count   = cnt_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wdata;
	end

endmodule

// ----- hw/rtl/tld_front.sv -----
module tld_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic                       func,
	input  logic [7:0]                 char_in,
	input  logic [tld_pkg::LEN_W-1:0]  read_len,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [15:0]                cfg_data,
	input  logic                       cmd_full,
	output logic                       cmd_push,
	output tld_pkg::cmd_t              cmd_word
);

	logic        canon_q, sigkeys_q;
	logic [15:0] fgroup_q;
	logic        drop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canon_q   <= 1'b1;
			sigkeys_q <= 1'b1;
			fgroup_q  <= 16'd1;
		end else if (cfg_valid) begin
			case (tld_pkg::cfg_idx_t'(cfg_index))
				tld_pkg::CFG_CANON:   canon_q   <= cfg_data[0];
				tld_pkg::CFG_SIGKEYS: sigkeys_q <= cfg_data[0];
				tld_pkg::CFG_FGROUP:  fgroup_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// classify the incoming word into a back-end command; Ctrl+Z is swallowed here when signal keys are enabled
	always_comb begin
		drop           = 1'b0;
		cmd_word.op    = tld_pkg::OP_APPEND;
		cmd_word.chr   = char_in;
		cmd_word.group = fgroup_q;
		cmd_word.len   = (read_len > tld_pkg::LEN_W'(tld_pkg::MAX_READ)) ?
			tld_pkg::LEN_W'(tld_pkg::MAX_READ) : read_len;
		if (func) begin
			cmd_word.op = canon_q ? tld_pkg::OP_READ_LINE : tld_pkg::OP_READ_RAW;
		end else if (sigkeys_q && char_in == tld_pkg::KEY_INTR) begin
			cmd_word.op = tld_pkg::OP_INTR;
		end else if (sigkeys_q && char_in == tld_pkg::KEY_STOP) begin
			drop = 1'b1;
		end else if (!canon_q) begin
			cmd_word.op = tld_pkg::OP_RAW;
		end else if (char_in == tld_pkg::KEY_BS || char_in == tld_pkg::KEY_DEL) begin
			cmd_word.op = tld_pkg::OP_ERASE;
		end else if (char_in == tld_pkg::KEY_CR || char_in == tld_pkg::KEY_LF) begin
			cmd_word.op = tld_pkg::OP_NEWLINE;
		end
	end

	assign cmd_push = push && !cmd_full && !drop;

endmodule

// ----- hw/rtl/tld_back.sv -----
module tld_back #(
	parameter int DEPTH    = tld_pkg::BUFFER_DEPTH,
	parameter int RQ_DEPTH = tld_pkg::RESQ_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_empty,
	input  tld_pkg::cmd_t                 cmd,
	output logic                          cmd_pop,
	input  logic [$clog2(RQ_DEPTH+1)-1:0] res_count,
	output logic                          res_push,
	output tld_pkg::res_t                 res_word
);

	localparam int AW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);
	localparam int CW = $clog2(RQ_DEPTH + 1);
	localparam int NW = tld_pkg::LEN_W;

	tld_pkg::back_state_t state_q, state_d;

	logic [7:0]    line_mem [DEPTH];
	logic [7:0]    fifo_mem [DEPTH];
	logic [LW-1:0] line_len_q, line_len_d;
	logic [LW-1:0] fcnt_q, fcnt_d;
	logic [AW-1:0] head_q, head_d, tail_q, tail_d;
	logic [AW-1:0] ridx_q, ridx_d;
	logic [NW-1:0] rem_q, rem_d;
	logic          rd_v_s1, rd_last_s1, rd_raw_s1;
	logic [7:0]    line_rd_s1, fifo_rd_s1;

	logic          line_we, fifo_we, line_re, fifo_re;
	logic [AW-1:0] line_waddr;
	logic [7:0]    line_wdata;
	logic          issue, issue_last;
	logic          room;
	logic [NW-1:0] n_line, n_raw;

	// a word may be issued only if the result queue can still take it after the one in flight
	assign room = ((CW+1)'(res_count) + (CW+1)'(rd_v_s1)) < (CW+1)'(RQ_DEPTH);

	assign n_line = (cmd.len < NW'(line_len_q)) ? cmd.len : NW'(line_len_q);
	assign n_raw  = (cmd.len < NW'(fcnt_q)) ? cmd.len : NW'(fcnt_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			tld_pkg::ST_IDLE: begin
				if (!cmd_empty && room && !rd_v_s1) begin
					if (cmd.op == tld_pkg::OP_READ_LINE && n_line != '0)
						state_d = tld_pkg::ST_READ_LINE;
					else if (cmd.op == tld_pkg::OP_READ_RAW && n_raw != '0)
						state_d = tld_pkg::ST_READ_RAW;
				end
			end
			tld_pkg::ST_READ_LINE, tld_pkg::ST_READ_RAW: begin
				if (room && rem_q == NW'(1))
					state_d = tld_pkg::ST_IDLE;
			end
			default: state_d = tld_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop    = 1'b0;
		res_push   = 1'b0;
		res_word   = '{kind: tld_pkg::KIND_DATA, data: 8'd0, last: 1'b0, group: 16'd0};
		line_we    = 1'b0;
		line_waddr = line_len_q[AW-1:0];
		line_wdata = cmd.chr;
		fifo_we    = 1'b0;
		line_re    = 1'b0;
		fifo_re    = 1'b0;
		issue      = 1'b0;
		issue_last = (rem_q == NW'(1));
		line_len_d = line_len_q;
		fcnt_d     = fcnt_q;
		head_d     = head_q;
		tail_d     = tail_q;
		ridx_d     = ridx_q;
		rem_d      = rem_q;

		// byte coming back from a memory read
		if (rd_v_s1) begin
			res_push      = 1'b1;
			res_word.data = rd_raw_s1 ? fifo_rd_s1 : line_rd_s1;
			res_word.last = rd_last_s1;
		end

		case (state_q)
			tld_pkg::ST_IDLE: begin
				if (!cmd_empty) begin
					case (cmd.op)
						tld_pkg::OP_INTR: begin
							if (room && !rd_v_s1) begin
								cmd_pop        = 1'b1;
								res_push       = 1'b1;
								res_word.kind  = tld_pkg::KIND_INTR;
								res_word.group = cmd.group;
							end
						end
						tld_pkg::OP_ERASE: begin
							cmd_pop = 1'b1;
							if (line_len_q != '0)
								line_len_d = line_len_q - LW'(1);
						end
						tld_pkg::OP_NEWLINE: begin
							cmd_pop = 1'b1;
							if (line_len_q < LW'(DEPTH)) begin
								line_we    = 1'b1;
								line_wdata = tld_pkg::KEY_LF;
								line_len_d = line_len_q + LW'(1);
							end
						end
						tld_pkg::OP_APPEND: begin
							cmd_pop = 1'b1;
							if (line_len_q < LW'(DEPTH - 1)) begin
								line_we    = 1'b1;
								line_len_d = line_len_q + LW'(1);
							end
						end
						tld_pkg::OP_RAW: begin
							cmd_pop = 1'b1;
							if (fcnt_q < LW'(DEPTH)) begin
								fifo_we = 1'b1;
								head_d  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
								fcnt_d  = fcnt_q + LW'(1);
							end
						end
						tld_pkg::OP_READ_LINE: begin
							if (room && !rd_v_s1) begin
								cmd_pop    = 1'b1;
								line_len_d = '0;
								ridx_d     = '0;
								rem_d      = n_line;
								if (n_line == '0) begin
									res_push      = 1'b1;
									res_word.kind = tld_pkg::KIND_EMPTY;
									res_word.last = 1'b1;
								end
							end
						end
						tld_pkg::OP_READ_RAW: begin
							if (room && !rd_v_s1) begin
								cmd_pop = 1'b1;
								rem_d   = n_raw;
								if (n_raw == '0) begin
									res_push      = 1'b1;
									res_word.kind = tld_pkg::KIND_EMPTY;
									res_word.last = 1'b1;
								end
							end
						end
						default: cmd_pop = 1'b1;
					endcase
				end
			end
			tld_pkg::ST_READ_LINE: begin
				if (room) begin
					issue   = 1'b1;
					line_re = 1'b1;
					ridx_d  = ridx_q + AW'(1);
					rem_d   = rem_q - NW'(1);
				end
			end
			tld_pkg::ST_READ_RAW: begin
				if (room) begin
					issue   = 1'b1;
					fifo_re = 1'b1;
					tail_d  = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + AW'(1);
					fcnt_d  = fcnt_q - LW'(1);
					rem_d   = rem_q - NW'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tld_pkg::ST_IDLE;
			line_len_q <= '0;
			fcnt_q     <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			ridx_q     <= '0;
			rem_q      <= '0;
			rd_v_s1    <= 1'b0;
			rd_last_s1 <= 1'b0;
			rd_raw_s1  <= 1'b0;
		end else begin
			state_q    <= state_d;
			line_len_q <= line_len_d;
			fcnt_q     <= fcnt_d;
			head_q     <= head_d;
			tail_q     <= tail_d;
			ridx_q     <= ridx_d;
			rem_q      <= rem_d;
			rd_v_s1    <= issue;
			if (issue) begin
				rd_last_s1 <= issue_last;
				rd_raw_s1  <= fifo_re;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (line_we)
			line_mem[line_waddr] <= line_wdata;
		if (line_re)
			line_rd_s1 <= line_mem[ridx_q];
	end

	always_ff @(posedge clk) begin
		if (fifo_we)
			fifo_mem[head_q] <= cmd.chr;
		if (fifo_re)
			fifo_rd_s1 <= fifo_mem[tail_q];
	end

endmodule

// ----- hw/rtl/terminal_line_discipline_unit.sv -----
// channel   direction  handshake                    word
// input     in         push / full                  func, char_in, read_len
// result    out        empty / pop                  result_kind, data_byte, last_byte,
//                                                   signal_group
// config    in         cfg_valid / cfg_ready        cfg_index, cfg_data
//
// A character word is taken by the back end from the 2-entry command queue while it is idle.
// A read of n bytes gives n data words, the last one marked (n = 0 gives one empty-read word);
// the bytes come one per cycle from a single read port of the line store or raw FIFO,
// as long as the 4-entry result queue has room; a stalled pop stops byte issue when it fills.
// Reset is asynchronous and sets all control state to its reset values; the stores need no clearing pass.
module terminal_line_discipline_unit #(
	parameter int BUFFER_DEPTH = tld_pkg::BUFFER_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic                      func,
	input  logic [7:0]                char_in,
	input  logic [tld_pkg::LEN_W-1:0] read_len,
	output logic                      empty,
	input  logic                      pop,
	output logic [1:0]                result_kind,
	output logic [7:0]                data_byte,
	output logic                      last_byte,
	output logic [15:0]               signal_group,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [15:0]               cfg_data
);

	localparam int CMD_W = $bits(tld_pkg::cmd_t);
	localparam int RES_W = $bits(tld_pkg::res_t);

	logic                                     cmd_push, cmd_pop, cmd_full, cmd_empty;
	tld_pkg::cmd_t                            cmd_in, cmd_out;
	logic [CMD_W-1:0]                         cmd_rdata;
	logic [$clog2(tld_pkg::CMDQ_DEPTH+1)-1:0] cmd_count;
	logic                                     res_push, res_full;
	tld_pkg::res_t                            res_in, res_out;
	logic [RES_W-1:0]                         res_rdata;
	logic [$clog2(tld_pkg::RESQ_DEPTH+1)-1:0] res_count;

	tld_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.func      (func),
		.char_in   (char_in),
		.read_len  (read_len),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_full  (cmd_full),
		.cmd_push  (cmd_push),
		.cmd_word  (cmd_in)
	);

	assign full = cmd_full;

	tld_fifo #(
		.W     (CMD_W),
		.DEPTH (tld_pkg::CMDQ_DEPTH)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (CMD_W'(cmd_in)),
		.pop    (cmd_pop),
		.rdata  (cmd_rdata),
		.full   (cmd_full),
		.empty  (cmd_empty),
		.count  (cmd_count)
	);

	assign cmd_out = tld_pkg::cmd_t'(cmd_rdata);

	tld_back #(
		.DEPTH    (BUFFER_DEPTH),
		.RQ_DEPTH (tld_pkg::RESQ_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_count (res_count),
		.res_push  (res_push),
		.res_word  (res_in)
	);

	tld_fifo #(
		.W     (RES_W),
		.DEPTH (tld_pkg::RESQ_DEPTH)
	) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (RES_W'(res_in)),
		.pop    (pop),
		.rdata  (res_rdata),
		.full   (res_full),
		.empty  (empty),
		.count  (res_count)
	);

	assign res_out      = tld_pkg::res_t'(res_rdata);
	assign result_kind  = res_out.kind;
	assign data_byte    = res_out.data;
	assign last_byte    = res_out.last;
	assign signal_group = res_out.group;

`ifndef SYNTHESIS
	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result word pushed into a full result queue");

	a_cmd_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> (!cmd_full && cmd_count != tld_pkg::CMDQ_DEPTH))
		else $error("command pushed into a full command queue");

	a_empty_read_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result_kind == tld_pkg::KIND_EMPTY) |-> (last_byte && data_byte == 8'd0))
		else $error("empty read word not marked last");

	a_intr_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result_kind == tld_pkg::KIND_INTR) |-> (!last_byte && data_byte == 8'd0))
		else $error("interrupt word carries data or last mark");
`endif

endmodule
